>>> hw/rtl/ogb_pkg.sv
package ogb_pkg;

    localparam int GRID_DIM_DEFAULT = 64;

    localparam int COORD_W = 16;
    localparam int CFG_W   = 16;
    localparam int COUNT_W = 16;
    localparam int FIELD_W = 6;
    localparam int IDX_W   = 8;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    localparam logic [COORD_W-1:0] SPAN_LIMIT     = 16'd44800;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [CFG_W-1:0]   CELL_EDGE_RESET = 16'd640;
    localparam logic [CFG_W-1:0]   MIN_HITS_RESET  = 16'd1;

    localparam logic REG_CELL_EDGE = 1'b0;
    localparam logic REG_MIN_HITS  = 1'b1;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic             is_read;
        logic             in_grid;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_CHECK
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_EXEC
    } back_state_t;

endpackage

>>> hw/rtl/occupancy_grid_point_binning.sv
// Occupancy grid point binner. Each input word either adds a point (tuser = 0; x and depth
// in unsigned Q10.6) to a GRID_DIM x GRID_DIM grid of saturating 16-bit hit counters, or
// reads and clears one cell (tuser = 1), which yields one output word with the count, the
// occupied flag (count >= min_hits) and the cell's column and row. Points outside the grid
// or beyond a lower cell edge of 700.0 are dropped silently. A point holds the input side
// while it is accepted, run through the bit-serial divider that turns x and depth into
// column and row, and range-checked and queued (held while the queue is full). A read is
// queued as it is accepted. The counter memory side takes each command as a registered
// read, then a write-back. After reset all 2^(2*clog2(GRID_DIM)) counter words (4096 at
// the default size) are swept to zero, and no word is accepted until it is done; APB writes work throughout.
// Registers: cell_edge at 0x0 (0 is treated as 1), min_hits at 0x4.
module occupancy_grid_point_binning #(
    parameter int GRID_DIM = ogb_pkg::GRID_DIM_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ogb_pkg::PADDR_W-1:0] paddr,
    input  logic [ogb_pkg::APB_W-1:0]   pwdata,
    output logic [ogb_pkg::APB_W-1:0]   prdata,
    output logic                        pready,

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [47:0]                 s_axis_tdata,  // point_x, point_depth, read_col, read_row
    input  logic                        s_axis_tuser,  // kind

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata   // hit_count, occupied, cell_col, cell_row
);
    import ogb_pkg::*;

    logic [CFG_W-1:0]    cell_edge_reg;
    logic [CFG_W-1:0]    min_hits_reg;
    logic                cfg_write;

    logic                clear_busy;
    logic                q_full;
    logic                q_empty;
    logic                push;
    logic                pop;
    cmd_t                push_cmd;
    cmd_t                head_cmd;

    logic [COUNT_W-1:0]  hit_count;
    logic                occupied;
    logic [FIELD_W-1:0]  cell_col;
    logic [FIELD_W-1:0]  cell_row;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MIN_HITS) ? APB_W'(min_hits_reg)
                                                  : APB_W'(cell_edge_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_edge_reg <= CELL_EDGE_RESET;
            min_hits_reg  <= MIN_HITS_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_MIN_HITS)
            begin
                min_hits_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                cell_edge_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    ogb_front #(
        .GRID_DIM (GRID_DIM)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .kind        (s_axis_tuser),
        .point_x     (s_axis_tdata[15:0]),
        .point_depth (s_axis_tdata[31:16]),
        .read_col    (s_axis_tdata[37:32]),
        .read_row    (s_axis_tdata[43:38]),
        .cell_edge   (cell_edge_reg),
        .clear_busy  (clear_busy),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    ogb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head_cmd),
        .empty    (q_empty)
    );

    ogb_back #(
        .GRID_DIM (GRID_DIM)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .cmd        (head_cmd),
        .pop        (pop),
        .clear_busy (clear_busy),
        .min_hits   (min_hits_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hit_count  (hit_count),
        .occupied   (occupied),
        .cell_col   (cell_col),
        .cell_row   (cell_row)
    );

    assign m_axis_tdata = {3'b000, cell_row, cell_col, occupied, hit_count};

endmodule

>>> hw/rtl/ogb_queue.sv
module ogb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ogb_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output ogb_pkg::cmd_t head,
    output logic          empty
);
    import ogb_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    cmd_t            entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [NW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hw/rtl/ogb_front.sv
module ogb_front #(
    parameter int GRID_DIM = ogb_pkg::GRID_DIM_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic [ogb_pkg::COORD_W-1:0] point_x,
    input  logic [ogb_pkg::COORD_W-1:0] point_depth,
    input  logic [ogb_pkg::FIELD_W-1:0] read_col,
    input  logic [ogb_pkg::FIELD_W-1:0] read_row,
    input  logic [ogb_pkg::CFG_W-1:0]   cell_edge,
    input  logic                        clear_busy,
    input  logic                        q_full,
    output logic                        push,
    output ogb_pkg::cmd_t               cmd
);
    import ogb_pkg::*;

    localparam int DIV_STEPS = COORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    front_state_t          state_reg;
    front_state_t          state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;

    logic [COORD_W-1:0]    d_reg;
    logic [COORD_W-1:0]    x_reg;
    logic [COORD_W-1:0]    z_reg;
    logic [COORD_W-1:0]    qx_reg;
    logic [COORD_W-1:0]    rx_reg;
    logic [COORD_W-1:0]    qz_reg;
    logic [COORD_W-1:0]    rz_reg;

    logic [COORD_W:0]      trial_x;
    logic [COORD_W:0]      trial_z;
    logic                  ge_x;
    logic                  ge_z;
    logic [COORD_W-1:0]    rx_step;
    logic [COORD_W-1:0]    rz_step;

    logic                  load_point;
    logic                  div_step;
    logic                  cell_ok;

    // one restoring step per cycle on each axis
    assign trial_x = {rx_reg, qx_reg[COORD_W-1]};
    assign trial_z = {rz_reg, qz_reg[COORD_W-1]};
    assign ge_x    = (trial_x >= {1'b0, d_reg});
    assign ge_z    = (trial_z >= {1'b0, d_reg});
    assign rx_step = ge_x ? COORD_W'(trial_x - {1'b0, d_reg}) : trial_x[COORD_W-1:0];
    assign rz_step = ge_z ? COORD_W'(trial_z - {1'b0, d_reg}) : trial_z[COORD_W-1:0];

    // quotient*edge = coord - remainder
    assign cell_ok = (qx_reg < COORD_W'(GRID_DIM)) && (qz_reg < COORD_W'(GRID_DIM))
                     && ((x_reg - rx_reg) <= SPAN_LIMIT)
                     && ((z_reg - rz_reg) <= SPAN_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        load_point = 1'b0;
        div_step   = 1'b0;
        cmd        = '0;
        case (state_reg)
            F_IDLE:
            begin
                in_ready = !clear_busy && !q_full;
                if (in_valid && in_ready)
                begin
                    if (kind == KIND_READ)
                    begin
                        push        = 1'b1;
                        cmd.is_read = 1'b1;
                        cmd.in_grid = ({3'b000, read_col} < 9'(GRID_DIM))
                                      && ({3'b000, read_row} < 9'(GRID_DIM));
                        cmd.col     = IDX_W'(read_col);
                        cmd.row     = IDX_W'(read_row);
                    end
                    else
                    begin
                        load_point = 1'b1;
                        cnt_next   = '0;
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = F_CHECK;
                end
            end
            F_CHECK:
            begin
                cmd.is_read = 1'b0;
                cmd.in_grid = 1'b1;
                cmd.col     = qx_reg[IDX_W-1:0];
                cmd.row     = qz_reg[IDX_W-1:0];
                if (!cell_ok)
                begin
                    state_next = F_IDLE;
                end
                else if (!q_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_point)
        begin
            d_reg  <= (cell_edge == '0) ? COORD_W'(1) : cell_edge;
            x_reg  <= point_x;
            z_reg  <= point_depth;
            qx_reg <= point_x;
            qz_reg <= point_depth;
            rx_reg <= '0;
            rz_reg <= '0;
        end
        else if (div_step)
        begin
            qx_reg <= {qx_reg[COORD_W-2:0], ge_x};
            qz_reg <= {qz_reg[COORD_W-2:0], ge_z};
            rx_reg <= rx_step;
            rz_reg <= rz_step;
        end
    end

endmodule

>>> hw/rtl/ogb_back.sv
module ogb_back #(
    parameter int GRID_DIM = ogb_pkg::GRID_DIM_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  ogb_pkg::cmd_t               cmd,
    output logic                        pop,
    output logic                        clear_busy,
    input  logic [ogb_pkg::CFG_W-1:0]   min_hits,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ogb_pkg::COUNT_W-1:0] hit_count,
    output logic                        occupied,
    output logic [ogb_pkg::FIELD_W-1:0] cell_col,
    output logic [ogb_pkg::FIELD_W-1:0] cell_row
);
    import ogb_pkg::*;

    localparam int CW        = $clog2(GRID_DIM);
    localparam int AW        = 2 * CW;
    localparam int MEM_DEPTH = 1 << AW;

    logic [COUNT_W-1:0]  cell_mem [MEM_DEPTH];
    logic [COUNT_W-1:0]  rd_data_reg;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [AW-1:0]       clr_addr_reg;
    logic [AW-1:0]       clr_addr_next;
    cmd_t                cmd_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [COUNT_W-1:0]  count_reg;
    logic                occ_reg;
    logic [FIELD_W-1:0]  col_reg;
    logic [FIELD_W-1:0]  row_reg;

    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       cur_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [COUNT_W-1:0]  wr_data;
    logic                load_out;
    logic [COUNT_W-1:0]  count_cur;

    assign rd_addr   = {cmd.row[CW-1:0], cmd.col[CW-1:0]};
    assign cur_addr  = {cmd_reg.row[CW-1:0], cmd_reg.col[CW-1:0]};
    assign count_cur = cmd_reg.in_grid ? rd_data_reg : '0;

    assign clear_busy = (state_reg == B_CLEAR);
    assign out_valid  = out_valid_reg;
    assign hit_count  = count_reg;
    assign occupied   = occ_reg;
    assign cell_col   = col_reg;
    assign cell_row   = row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        pop           = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = cur_addr;
        wr_data       = '0;
        load_out      = 1'b0;
        case (state_reg)
            B_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty && (!out_valid_reg || !cmd.is_read))
                begin
                    pop        = 1'b1;
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                if (cmd_reg.is_read)
                begin
                    load_out = 1'b1;
                    wr_en    = cmd_reg.in_grid;
                    wr_data  = '0;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_data = (rd_data_reg == COUNT_MAX) ? COUNT_MAX : rd_data_reg + 1'b1;
                end
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= cell_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= cmd;
        end
        if (load_out)
        begin
            count_reg <= count_cur;
            occ_reg   <= (count_cur >= min_hits);
            col_reg   <= cmd_reg.col[FIELD_W-1:0];
            row_reg   <= cmd_reg.row[FIELD_W-1:0];
        end
    end

endmodule

>>> tb/sv/tb_occupancy_grid_point_binning.sv
module tb_occupancy_grid_point_binning;
    import ogb_pkg::*;

    localparam int RUN_LIMIT     = 400000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_WORDS  = 950;
    localparam int PHASES        = 6;
    localparam int GRID          = GRID_DIM_DEFAULT;

    // input word, from bit 0 up: point_x, point_depth, read_col, read_row, pad
    typedef struct packed {
        logic [3:0]         pad;
        logic [5:0]         read_row;
        logic [5:0]         read_col;
        logic [COORD_W-1:0] point_depth;
        logic [COORD_W-1:0] point_x;
    } in_word_t;

    // output word, from bit 0 up: hit_count, occupied, cell_col, cell_row, pad
    typedef struct packed {
        logic [2:0]         pad;
        logic [5:0]         cell_row;
        logic [5:0]         cell_col;
        logic               occupied;
        logic [COUNT_W-1:0] hit_count;
    } cell_report_t;

    class grid_tally;
        bit [COUNT_W-1:0] hits [GRID*GRID];
        bit [CFG_W-1:0]   cell_edge;
        bit [CFG_W-1:0]   min_hits;
        cell_report_t     expected_reports [$];
        int               errors;

        function new();
            foreach (hits[i])
                hits[i] = '0;
            cell_edge = CELL_EDGE_RESET;
            min_hits  = MIN_HITS_RESET;
            errors    = 0;
        endfunction

        function void write_reg(logic idx, bit [CFG_W-1:0] value);
            if (idx == REG_CELL_EDGE)
                cell_edge = value;
            else
                min_hits = value;
        endfunction

        // half-open cells; lower edge must stay within the span limit
        function bit axis_cell(int unsigned coord, output int unsigned k);
            int unsigned e;
            e = (cell_edge == 0) ? 1 : cell_edge;
            k = coord / e;
            return (k < GRID) && (k * e <= SPAN_LIMIT);
        endfunction

        function void take_word(logic kind, in_word_t w);
            int unsigned  col;
            int unsigned  row;
            int unsigned  a;
            cell_report_t r;
            if (kind == KIND_POINT)
            begin
                if (axis_cell(w.point_x, col) && axis_cell(w.point_depth, row))
                begin
                    a = row * GRID + col;
                    if (hits[a] != COUNT_MAX)
                        hits[a] = hits[a] + 1'b1;
                end
            end
            else
            begin
                r = '0;
                if (w.read_col < GRID && w.read_row < GRID)
                begin
                    a = w.read_row * GRID + w.read_col;
                    r.hit_count = hits[a];
                    hits[a] = '0;
                end
                r.occupied = (r.hit_count >= min_hits);
                r.cell_col = w.read_col;
                r.cell_row = w.read_row;
                expected_reports.insert(expected_reports.size(), r);
            end
        endfunction

        function void check_report(cell_report_t got);
            cell_report_t want;
            if (expected_reports.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected report: count %0d occ %0d col %0d row %0d",
                             got.hit_count, got.occupied, got.cell_col, got.cell_row);
                return;
            end
            want = expected_reports.pop_front();
            if (got.hit_count !== want.hit_count || got.occupied !== want.occupied ||
                got.cell_col !== want.cell_col || got.cell_row !== want.cell_row)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             want.hit_count, want.occupied, want.cell_col, want.cell_row,
                             got.hit_count, got.occupied, got.cell_col, got.cell_row);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [APB_W-1:0]   pwdata = '0;
    logic [APB_W-1:0]   prdata;
    logic               pready;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [47:0]        s_axis_tdata = '0;  // point_x, point_depth, read_col, read_row
    logic               s_axis_tuser = 1'b0;  // kind
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [31:0]        m_axis_tdata;  // hit_count, occupied, cell_col, cell_row

    grid_tally   board;
    int          send_idle = 26;
    int          recv_idle = 84;
    int unsigned cycles = 0;

    occupancy_grid_point_binning dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_report(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task apb_write(logic idx, bit [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_W-CFG_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task send_word(logic kind, int unsigned x, int unsigned z, int unsigned c, int unsigned r);
        in_word_t w;
        w             = '0;
        w.point_x     = x[COORD_W-1:0];
        w.point_depth = z[COORD_W-1:0];
        w.read_col    = c[5:0];
        w.read_row    = r[5:0];
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.take_word(kind, w);
    endtask

    // drop valid, wait for every report, then cover points still in the divider
    task settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function int unsigned grid_reach(int unsigned e);
        int unsigned k;
        k = GRID - 1;
        if (SPAN_LIMIT / e < k)
            k = SPAN_LIMIT / e;
        if (65535 / e < k)
            k = 65535 / e;
        return k;
    endfunction

    function int unsigned cell_coord(int unsigned k, int unsigned e);
        int unsigned base;
        int unsigned span;
        base = k * e;
        span = e - 1;
        if (span > 65535 - base)
            span = 65535 - base;
        if ($urandom_range(0, 3) == 0)
            return base;
        return base + $urandom_range(0, span);
    endfunction

    task run_phase(int words, bit hold_off);
        int unsigned e;
        int unsigned kmax;
        int unsigned hot_col [6];
        int unsigned hot_row [6];
        int unsigned h;
        int unsigned roll;
        e    = (board.cell_edge == 0) ? 1 : board.cell_edge;
        kmax = grid_reach(e);
        foreach (hot_col[i])
        begin
            hot_col[i] = $urandom_range(0, kmax);
            hot_row[i] = $urandom_range(0, kmax);
        end
        for (int n = 0; n < words; n++)
        begin
            roll = $urandom_range(0, 99);
            h    = $urandom_range(0, 5);
            if (roll < 62)
                send_word(KIND_POINT, cell_coord(hot_col[h], e), cell_coord(hot_row[h], e),
                          $urandom_range(0, 63), $urandom_range(0, 63));
            else if (roll < 80)
                send_word(KIND_READ, $urandom_range(0, 65535), $urandom_range(0, 65535),
                          hot_col[h], hot_row[h]);
            else if (roll < 90)
                send_word(KIND_POINT, $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 63), $urandom_range(0, 63));
            else
                send_word(KIND_READ, $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 63), $urandom_range(0, 63));
            if (hold_off && n == words / 2)
            begin
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (board.expected_reports.size() != 0);
            end
        end
    endtask

    initial
    begin
        bit [CFG_W-1:0] edges [PHASES];
        bit [CFG_W-1:0] thresholds [PHASES];
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: edge 10.0, threshold 1
        send_word(KIND_POINT, 0, 0, 0, 0);
        send_word(KIND_POINT, 639, 639, 0, 0);
        send_word(KIND_POINT, 640, 0, 0, 0);
        send_word(KIND_POINT, 40959, 65535, 0, 0);
        send_word(KIND_POINT, 65535, 0, 0, 0);
        send_word(KIND_POINT, 40959, 40959, 0, 0);
        send_word(KIND_READ, 0, 0, 0, 0);
        send_word(KIND_READ, 0, 0, 1, 0);
        send_word(KIND_READ, 65535, 65535, 63, 63);
        send_word(KIND_READ, 0, 0, 0, 0);
        settle();

        // zero edge behaves as 1
        apb_write(REG_CELL_EDGE, 16'd0);
        apb_write(REG_MIN_HITS, 16'hFFFF);
        send_word(KIND_POINT, 63, 0, 0, 0);
        send_word(KIND_POINT, 64, 0, 0, 0);
        send_word(KIND_READ, 0, 0, 63, 0);
        settle();

        // span limit at 700.0, zero threshold
        apb_write(REG_CELL_EDGE, 16'd1000);
        apb_write(REG_MIN_HITS, 16'd0);
        send_word(KIND_POINT, 44999, 999, 0, 0);
        send_word(KIND_POINT, 45000, 0, 0, 0);
        send_word(KIND_READ, 0, 0, 44, 0);
        send_word(KIND_READ, 0, 0, 45, 0);
        settle();

        apb_write(REG_CELL_EDGE, 16'hFFFF);
        apb_write(REG_MIN_HITS, 16'd2);
        send_word(KIND_POINT, 65534, 65534, 0, 0);
        send_word(KIND_POINT, 65535, 0, 0, 0);
        send_word(KIND_POINT, 0, 0, 0, 0);
        send_word(KIND_READ, 0, 0, 0, 0);
        settle();

        // last column cut by the span limit rather than the grid size
        apb_write(REG_CELL_EDGE, 16'd712);
        send_word(KIND_POINT, 44855, 0, 0, 0);
        send_word(KIND_POINT, 44856, 0, 0, 0);
        send_word(KIND_READ, 0, 0, 62, 0);
        send_word(KIND_READ, 0, 0, 63, 0);

        edges      = '{16'd711, 16'd1, 16'hFFFF, 16'd640, 16'd0, 16'd0};
        thresholds = '{16'd2, 16'd1, 16'hFFFF, 16'd3, 16'd1, 16'd0};
        edges[5]      = CFG_W'($urandom_range(2, 3000));
        thresholds[5] = CFG_W'($urandom_range(0, 4));
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            apb_write(REG_CELL_EDGE, edges[p]);
            apb_write(REG_MIN_HITS, thresholds[p]);
            case (p / 2)
                0:
                begin
                    send_idle = 26;
                    recv_idle = 84;
                end
                1:
                begin
                    send_idle = 84;
                    recv_idle = 26;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            run_phase(RANDOM_WORDS / PHASES + 1, p == 1);
        end
        settle();

        if (board.errors == 0 && board.expected_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ogb_pkg.sv
hw/rtl/ogb_queue.sv
hw/rtl/ogb_front.sv
hw/rtl/ogb_back.sv
hw/rtl/occupancy_grid_point_binning.sv
tb/sv/tb_occupancy_grid_point_binning.sv
